// ----- rtl/servo_angle_ramp_pwm_macros.svh -----
// assertion macros shared by the servo angle ramp rtl
`ifndef SERVO_ANGLE_RAMP_PWM_MACROS_SVH
`define SERVO_ANGLE_RAMP_PWM_MACROS_SVH

// same-cycle implication, held off while in reset
`define SARP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off while in reset
`define SARP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sarp_pkg.sv -----
// shared types, constants and control structs for the servo angle ramp block
package sarp_pkg;

    localparam int NUM_SERVOS_DEF = 3;
    localparam int NUM_CAL_REGS   = 3;

    localparam int CMD_W   = 2;
    localparam int CH_W    = 2;
    localparam int ANG_W   = 11;
    localparam int SPEED_W = 10;
    localparam int DELAY_W = 16;
    localparam int PULSE_W = 14;
    localparam int CAL_W   = 50;
    localparam int IDX_W   = 2;

    // divider sizing: product of angle offset and pulse span, divided by angle span
    localparam int DVD_W = 25;
    localparam int DVS_W = 11;
    localparam int CNT_W = 5;

    localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RAMP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    typedef logic signed [ANG_W-1:0] t_angle;
    typedef logic [CAL_W-1:0]        t_cal;

    typedef struct packed {
        logic capture;
        logic cancel;
        logic set_emit;
        logic ramp_div;
        logic ramp_setup;
        logic hold_dec;
        logic tick_emit;
        logic map_mul;
        logic map_div;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             ch_ok;
        logic             ramp_active;
        logic             hold_zero;
        logic             hold_one;
        logic             ramp_none;
        logic             steps_zero;
        logic             div_done;
        logic             out_free;
    } t_stat;

    function automatic t_angle cal_min(input t_cal c);
        return t_angle'(c[10:0]);
    endfunction

    function automatic t_angle cal_max(input t_cal c);
        return t_angle'(c[21:11]);
    endfunction

    function automatic logic [PULSE_W-1:0] cal_plo(input t_cal c);
        return c[35:22];
    endfunction

    function automatic logic [PULSE_W-1:0] cal_phi(input t_cal c);
        return c[49:36];
    endfunction

endpackage

// ----- rtl/sarp_if.sv -----
// handshake channel interfaces: command word in, result word out, calibration writes
interface sarp_in_if import sarp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [CH_W-1:0]      channel;
    t_angle               goal_angle;
    t_angle               start_angle;
    logic [SPEED_W-1:0]   step_speed;
    logic [DELAY_W-1:0]   step_delay;

    modport source(output valid, command, channel, goal_angle, start_angle,
                   step_speed, step_delay, input ready);
    modport sink(input valid, command, channel, goal_angle, start_angle,
                 step_speed, step_delay, output ready);
endinterface

interface sarp_out_if import sarp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CH_W-1:0]      out_channel;
    t_angle               out_angle;
    logic [PULSE_W-1:0]   pulse_width;
    logic                 last_step;

    modport source(output valid, out_channel, out_angle, pulse_width, last_step,
                   input ready);
    modport sink(input valid, out_channel, out_angle, pulse_width, last_step,
                 output ready);
endinterface

interface sarp_cfg_if import sarp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [IDX_W-1:0]     index;
    t_cal                 data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/sarp_div.sv -----
// restoring divider, one quotient bit per cycle, variable bit count
module sarp_div import sarp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    input  logic [CNT_W-1:0] i_nbits,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient,
    output logic [DVS_W-1:0] o_remainder
);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   w_trial;
    logic             w_fits;
    logic [DVS_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[DVD_W-1]};
    assign w_fits  = (w_trial >= {1'b0, r_dvs});
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_nbits;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // left-aligned dividend: quotient bits shift in from the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], w_fits};
            r_rem <= w_fits ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_dvd;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/sarp_ctrl.sv -----
// sequencing state machine for set, ramp and tick commands
`include "servo_angle_ramp_pwm_macros.svh"

module sarp_ctrl import sarp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECODE = 8'b0000_0010,
        S_RWAIT  = 8'b0000_0100,
        S_RSETUP = 8'b0000_1000,
        S_MUL    = 8'b0001_0000,
        S_MDIV   = 8'b0010_0000,
        S_MWAIT  = 8'b0100_0000,
        S_DONE   = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_IDLE;
                unique case (i_stat.command)
                    CMD_SET: begin
                        if (i_stat.ch_ok) begin
                            o_cmd.cancel   = 1'b1;
                            o_cmd.set_emit = 1'b1;
                            n_state        = S_MUL;
                        end
                    end
                    CMD_RAMP: begin
                        if (i_stat.ch_ok) begin
                            o_cmd.cancel = 1'b1;
                            if (!i_stat.ramp_none) begin
                                o_cmd.ramp_div = 1'b1;
                                n_state        = S_RWAIT;
                            end
                        end
                    end
                    CMD_TICK: begin
                        if (i_stat.ramp_active) begin
                            // still holding the current step
                            if (!i_stat.hold_zero && !i_stat.hold_one) begin
                                o_cmd.hold_dec = 1'b1;
                            end else begin
                                o_cmd.tick_emit = 1'b1;
                                n_state         = S_MUL;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_RWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_RSETUP;
                end
            end
            S_RSETUP: begin
                o_cmd.ramp_setup = 1'b1;
                n_state          = i_stat.steps_zero ? S_IDLE : S_MUL;
            end
            S_MUL: begin
                o_cmd.map_mul = 1'b1;
                n_state       = S_MDIV;
            end
            S_MDIV: begin
                o_cmd.map_div = 1'b1;
                n_state       = S_MWAIT;
            end
            S_MWAIT: begin
                if (i_stat.div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    `SARP_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, o_cmd.out_load, i_stat.out_free, "result word loaded over a pending one")
    `SARP_ASSERT_IMP(a_div_after_mul, i_clk, i_rst_n, o_cmd.map_div, $past(o_cmd.map_mul), "map division started without a product")
    `SARP_ASSERT_IMP(a_setup_after_div, i_clk, i_rst_n, o_cmd.ramp_setup, $past(i_stat.div_done), "ramp setup before step count ready")

endmodule

// ----- rtl/sarp_dp.sv -----
// datapath: calibration registers, ramp state, clamp, linear map and result register
`include "servo_angle_ramp_pwm_macros.svh"

module sarp_dp import sarp_pkg::*; #(
    parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [CH_W-1:0]    i_channel,
    input  t_angle             i_goal_angle,
    input  t_angle             i_start_angle,
    input  logic [SPEED_W-1:0] i_step_speed,
    input  logic [DELAY_W-1:0] i_step_delay,
    input  logic               i_cfg_valid,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  t_cal               i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [CH_W-1:0]    o_out_channel,
    output t_angle             o_out_angle,
    output logic [PULSE_W-1:0] o_pulse_width,
    output logic               o_last_step
);

    localparam int CAL_DEPTH = (NUM_SERVOS < NUM_CAL_REGS) ? NUM_SERVOS : NUM_CAL_REGS;
    localparam int CAL_IW    = (CAL_DEPTH > 1) ? $clog2(CAL_DEPTH) : 1;
    localparam int SA_W      = ANG_W + 1;

    // calibration registers
    t_cal r_cal [CAL_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CAL_DEPTH; k++) begin
                r_cal[k] <= '0;
            end
        end else if (i_cfg_valid && (32'(i_cfg_index) < CAL_DEPTH)) begin
            r_cal[i_cfg_index[CAL_IW-1:0]] <= i_cfg_data;
        end
    end

    // captured command word
    logic [CMD_W-1:0]   r_cmd_code;
    logic [CH_W-1:0]    r_chan;
    t_angle             r_target;
    t_angle             r_start;
    logic [SPEED_W-1:0] r_speed;
    logic [DELAY_W-1:0] r_delay;

    // ramp state
    logic               r_ramp_active;
    logic [CH_W-1:0]    r_ramp_ch;
    logic signed [SA_W-1:0] r_next;
    logic signed [SA_W-1:0] r_sstep;
    logic [ANG_W-1:0]   r_steps_left;
    logic [DELAY_W-1:0] r_hold_reload;
    logic [DELAY_W-1:0] r_hold_count;

    // map pipeline
    logic signed [SA_W-1:0] r_ang;
    logic               r_last;
    t_angle             r_out_ang;
    logic [DVD_W-1:0]   r_prod;
    logic               r_neg;

    // result register
    logic               r_o_valid;
    logic [CH_W-1:0]    r_o_chan;
    t_angle             r_o_ang;
    logic [PULSE_W-1:0] r_o_pulse;
    logic               r_o_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd_code <= i_command;
            r_chan     <= (i_command == CMD_TICK) ? r_ramp_ch : i_channel;
            r_target   <= i_goal_angle;
            r_start    <= i_start_angle;
            r_speed    <= i_step_speed;
            r_delay    <= i_step_delay;
        end
    end

    // calibration of the addressed channel
    t_cal               w_cal;
    t_angle             w_lo;
    t_angle             w_hi;
    logic [PULSE_W-1:0] w_plo;
    logic [PULSE_W-1:0] w_phi;
    logic signed [SA_W-1:0] w_span;
    logic [DVS_W-1:0]   w_span_mag;
    logic               w_span_zero;

    assign w_cal       = (32'(r_chan) < CAL_DEPTH) ? r_cal[r_chan[CAL_IW-1:0]] : '0;
    assign w_lo        = cal_min(w_cal);
    assign w_hi        = cal_max(w_cal);
    assign w_plo       = cal_plo(w_cal);
    assign w_phi       = cal_phi(w_cal);
    assign w_span      = SA_W'(w_hi) - SA_W'(w_lo);
    assign w_span_mag  = w_span[SA_W-1] ? DVS_W'(-w_span) : w_span[DVS_W-1:0];
    assign w_span_zero = (w_lo == w_hi);

    // ramp distance
    logic signed [SA_W-1:0] w_diff;
    logic [SA_W-1:0]    w_ad_full;
    logic [ANG_W-1:0]   w_ad;

    assign w_diff    = SA_W'(r_target) - SA_W'(r_start);
    assign w_ad_full = w_diff[SA_W-1] ? SA_W'(-w_diff) : w_diff;
    assign w_ad      = w_ad_full[ANG_W-1:0];

    // divider
    logic               w_div_start;
    logic [DVD_W-1:0]   w_dividend;
    logic [DVS_W-1:0]   w_divisor;
    logic [CNT_W-1:0]   w_nbits;
    logic               w_div_done;
    logic [DVD_W-1:0]   w_quot;
    logic [DVS_W-1:0]   w_rem_full;

    assign w_div_start = i_cmd.ramp_div || i_cmd.map_div;
    // step count needs only the angle width of quotient bits
    assign w_dividend  = i_cmd.ramp_div ? {w_ad, {(DVD_W-ANG_W){1'b0}}} : r_prod;
    assign w_divisor   = i_cmd.ramp_div ? DVS_W'(r_speed) : w_span_mag;
    assign w_nbits     = i_cmd.ramp_div ? CNT_W'(ANG_W) : CNT_W'(DVD_W);

    sarp_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (w_dividend),
        .i_divisor   (w_divisor),
        .i_nbits     (w_nbits),
        .o_done      (w_div_done),
        .o_quotient  (w_quot),
        .o_remainder (w_rem_full)
    );

    // ramp setup from step count and remainder
    logic [ANG_W-1:0]   w_steps;
    logic [SPEED_W-1:0] w_rem;
    logic [ANG_W-1:0]   w_adv;
    logic signed [SA_W-1:0] w_first;
    logic signed [SA_W-1:0] w_sstep;

    assign w_steps = w_quot[ANG_W-1:0];
    assign w_rem   = w_rem_full[SPEED_W-1:0];
    assign w_adv   = ANG_W'(r_speed) + ANG_W'(w_rem);
    assign w_first = w_diff[SA_W-1] ? (SA_W'(r_start) - SA_W'(w_adv))
                                    : (SA_W'(r_start) + SA_W'(w_adv));
    assign w_sstep = w_diff[SA_W-1] ? -SA_W'(r_speed) : SA_W'(r_speed);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_active <= 1'b0;
            r_ramp_ch     <= '0;
            r_next        <= '0;
            r_sstep       <= '0;
            r_steps_left  <= '0;
            r_hold_reload <= '0;
            r_hold_count  <= '0;
        end else if (i_cmd.cancel) begin
            r_ramp_active <= 1'b0;
        end else if (i_cmd.hold_dec) begin
            r_hold_count <= r_hold_count - DELAY_W'(1);
        end else if (i_cmd.tick_emit) begin
            r_steps_left <= r_steps_left - ANG_W'(1);
            if (r_steps_left == ANG_W'(1)) begin
                r_ramp_active <= 1'b0;
                r_hold_count  <= '0;
            end else begin
                r_next       <= r_next + r_sstep;
                r_hold_count <= r_hold_reload;
            end
        end else if (i_cmd.ramp_setup && (w_steps > ANG_W'(1))) begin
            r_ramp_active <= 1'b1;
            r_ramp_ch     <= r_chan;
            r_sstep       <= w_sstep;
            r_next        <= w_first + w_sstep;
            r_steps_left  <= w_steps - ANG_W'(1);
            r_hold_reload <= r_delay;
            r_hold_count  <= r_delay;
        end
    end

    // angle to map
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_emit) begin
            r_ang  <= SA_W'(r_target);
            r_last <= 1'b1;
        end else if (i_cmd.tick_emit) begin
            r_ang  <= r_next;
            r_last <= (r_steps_left == ANG_W'(1));
        end else if (i_cmd.ramp_setup) begin
            r_ang  <= w_first;
            r_last <= (w_steps == ANG_W'(1));
        end
    end

    // clamp, then offset times pulse span
    logic signed [SA_W-1:0] w_a_hi;
    logic signed [SA_W-1:0] w_a_cl;
    logic signed [SA_W-1:0] w_off_full;
    logic [ANG_W-1:0]   w_off;
    logic signed [PULSE_W:0] w_pdiff;
    logic               w_pneg;
    logic [PULSE_W-1:0] w_pmag;

    assign w_a_hi     = (r_ang > SA_W'(w_hi)) ? SA_W'(w_hi) : r_ang;
    assign w_a_cl     = (w_a_hi < SA_W'(w_lo)) ? SA_W'(w_lo) : w_a_hi;
    assign w_off_full = w_a_cl - SA_W'(w_lo);
    assign w_off      = w_off_full[ANG_W-1:0];
    assign w_pdiff    = (PULSE_W+1)'(w_phi) - (PULSE_W+1)'(w_plo);
    assign w_pneg     = w_pdiff[PULSE_W];
    assign w_pmag     = w_pneg ? PULSE_W'(-w_pdiff) : w_pdiff[PULSE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.map_mul) begin
            r_prod    <= DVD_W'(w_off) * DVD_W'(w_pmag);
            r_neg     <= w_pneg;
            r_out_ang <= w_a_cl[ANG_W-1:0];
        end
    end

    // truncating quotient, signed by the pulse span
    logic [PULSE_W-1:0] w_q;
    logic [PULSE_W:0]   w_psum;
    logic [PULSE_W-1:0] w_pulse;

    assign w_q     = w_quot[PULSE_W-1:0];
    assign w_psum  = (PULSE_W+1)'(w_plo) +
                     (r_neg ? -(PULSE_W+1)'(w_q) : (PULSE_W+1)'(w_q));
    assign w_pulse = w_span_zero ? w_plo : w_psum[PULSE_W-1:0];

    logic w_out_free;
    assign w_out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_chan  <= r_chan;
            r_o_ang   <= r_out_ang;
            r_o_pulse <= w_pulse;
            r_o_last  <= r_last;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_out_channel = r_o_chan;
    assign o_out_angle   = r_o_ang;
    assign o_pulse_width = r_o_pulse;
    assign o_last_step   = r_o_last;

    always_comb begin
        o_stat             = '0;
        o_stat.command     = r_cmd_code;
        o_stat.ch_ok       = (32'(r_chan) < NUM_SERVOS);
        o_stat.ramp_active = r_ramp_active;
        o_stat.hold_zero   = (r_hold_count == '0);
        o_stat.hold_one    = (r_hold_count == DELAY_W'(1));
        o_stat.ramp_none   = (r_speed == '0) || (w_diff == '0) || w_span_zero;
        o_stat.steps_zero  = (w_steps == '0);
        o_stat.div_done    = w_div_done;
        o_stat.out_free    = w_out_free;
    end

    `SARP_ASSERT_IMP(a_active_has_steps, i_clk, i_rst_n, r_ramp_active, r_steps_left != '0, "ramp running with no steps left")
    `SARP_ASSERT_IMP(a_hold_in_range, i_clk, i_rst_n, 1'b1, r_hold_count <= r_hold_reload, "hold count above its reload")
    `SARP_ASSERT_IMP(a_tick_needs_ramp, i_clk, i_rst_n, i_cmd.tick_emit, r_ramp_active, "step emitted with no ramp running")
    `SARP_ASSERT_NXT(a_last_ends_ramp, i_clk, i_rst_n, i_cmd.tick_emit && (r_steps_left == ANG_W'(1)), !r_ramp_active, "ramp kept running past its final step")

endmodule

// ----- rtl/servo_angle_ramp_pwm.sv -----
// set or tick: the result is mapped by a multiply, then a full-width divider pass, before it is valid
// ramp start: a divider pass over the angle width for the step count comes first
// a tick that only counts down its hold gives no word
// one word in work at a time; the next is taken the cycle after the result is registered
// sync active-low reset clears calibration, ramp state, control and the result valid flag
module servo_angle_ramp_pwm import sarp_pkg::*; #(
    parameter int NUM_SERVOS = NUM_SERVOS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sarp_in_if.sink     i_in,
    sarp_out_if.source  o_out,
    sarp_cfg_if.sink    i_cfg
);

    t_cmd  w_cmd;
    t_stat w_stat;

    assign i_cfg.ready = 1'b1;

    sarp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    sarp_dp #(
        .NUM_SERVOS (NUM_SERVOS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_command      (i_in.command),
        .i_channel      (i_in.channel),
        .i_goal_angle   (i_in.goal_angle),
        .i_start_angle  (i_in.start_angle),
        .i_step_speed   (i_in.step_speed),
        .i_step_delay   (i_in.step_delay),
        .i_cfg_valid    (i_cfg.valid),
        .i_cfg_index    (i_cfg.index),
        .i_cfg_data     (i_cfg.data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_channel  (o_out.out_channel),
        .o_out_angle    (o_out.out_angle),
        .o_pulse_width  (o_out.pulse_width),
        .o_last_step    (o_out.last_step)
    );

endmodule
